[rtl/core/rfid_tag_read_field_parser_top_macros.svh]
// Assertion macros for the RFID tag-read field parser.
// No dependencies; included by the checker file.
// Macros are used only inside the checker module.
`ifndef RFID_TAG_READ_FIELD_PARSER_TOP_MACROS_SVH
`define RFID_TAG_READ_FIELD_PARSER_TOP_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define RFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rfp_pkg.sv]
// Package for the RFID tag-read field parser: phases, field kinds, constants.
// No dependencies; used by the interfaces, the top level and the checker.
package rfp_pkg;

    localparam int DATA_W  = 8;
    localparam int FLEN_W  = 11;
    localparam int LIMIT_W = 9;
    localparam int KIND_W  = 3;

    // Frame length bounds, held wide enough for any legal maximum
    localparam logic [16:0] MIN_FRAME_LEN = 17'd4;
    localparam logic [16:0] MAX_FRAME_LEN = 17'd1024;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd128;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_EPC_LEN  = 3'd1,
        PH_EPC      = 3'd2,
        PH_TID_LEN  = 3'd3,
        PH_TID      = 3'd4,
        PH_USER_LEN = 3'd5,
        PH_USER     = 3'd6
    } phase_t;

    // Field kind codes as seen on the result channel
    localparam logic [KIND_W-1:0] KIND_ANTENNA  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EPC_LEN  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EPC      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TID_LEN  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TID      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_USER_LEN = 3'd5;
    localparam logic [KIND_W-1:0] KIND_USER     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_IGNORED  = 3'd7;

endpackage

[rtl/core/rfp_ifs.sv]
// Handshake interfaces of the RFID tag-read field parser: bytes, results, config.
// Depends on rfp_pkg.
interface rfp_byte_if import rfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              frame_start;
    logic [FLEN_W-1:0] frame_length;

    modport source (output valid, data_byte, frame_start, frame_length, input ready);
    modport sink   (input valid, data_byte, frame_start, frame_length, output ready);
endinterface

interface rfp_field_if import rfp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] field_kind;
    logic [DATA_W-1:0] byte_value;
    logic [DATA_W-1:0] field_offset;
    logic              parse_error;
    logic              parse_done;

    modport source (output valid, field_kind, byte_value, field_offset, parse_error,
                    parse_done, input ready);
    modport sink   (input valid, field_kind, byte_value, field_offset, parse_error,
                    parse_done, output ready);
endinterface

interface rfp_cfg_if import rfp_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] field_len_limit;

    modport source (output valid, field_len_limit, input ready);
    modport sink   (input valid, field_len_limit, output ready);
endinterface

[rtl/core/rfid_tag_read_field_parser_top.sv]
// Top level of the RFID tag-read field parser: byte classifier with result register.
// Depends on rfp_pkg and the interfaces in rfp_ifs.sv.
//
//  channel  | dir  | item                                         | accepted when
//  ---------+------+----------------------------------------------+----------------
//  payload  | sink | data_byte, frame_start, frame_length         | valid && ready
//  labels   | src  | field_kind, byte_value, field_offset,        | valid && ready
//           |      | parse_error, parse_done                      |
//  cfg      | sink | field_len_limit                              | valid && ready
//
// One byte per cycle unless labels stalls: each accepted byte is classified in the cycle
// it is taken and its result sits in the result register from the next cycle on.
// The path is set by the length check, one 12-bit add and compare against the frame.
// payload.ready is high whenever the result register is empty or being emptied, so a
// stall on labels holds at most one result and stops input only in that cycle.
// cfg.ready is always high; the limit applies to bytes accepted after the write.
// Reset (rst_n low, asynchronous) leaves no frame open, limit 128, result register empty.
module rfid_tag_read_field_parser_top import rfp_pkg::*;
#(
    parameter logic [16:0] MAX_FRAME_BYTES = MAX_FRAME_LEN  // largest legal frame length
)
(
    input  logic       clk,
    input  logic       rst_n,
    rfp_cfg_if.sink    cfg,
    rfp_byte_if.sink   payload,
    rfp_field_if.source labels
);

    // Parser state
    phase_t             phase_reg,    phase_next;
    logic [FLEN_W-1:0]  pos_reg,      pos_next;     // index of next byte in frame
    logic [DATA_W-1:0]  left_reg,     left_next;    // data bytes still due
    logic [FLEN_W-1:0]  flen_reg,     flen_next;    // frame length of this frame
    logic               finished_reg, finished_next;
    logic [DATA_W-1:0]  idx_reg,      idx_next;     // offset of next data byte
    logic [LIMIT_W-1:0] limit_reg;

    // Result register
    logic               out_valid_reg;
    logic [KIND_W-1:0]  kind_reg,  kind_next;
    logic [DATA_W-1:0]  value_reg;
    logic [DATA_W-1:0]  off_reg,   off_next;
    logic               err_reg,   err_next;
    logic               done_reg,  done_next;

    logic accept;

    // Shared decode of the current byte
    logic               frame_bad;   // start byte with a short or oversized frame
    logic               len_zero;
    logic [FLEN_W:0]    end_pos;     // one past the last byte of the announced field
    logic               fits;
    logic               len_bad;
    logic [DATA_W-1:0]  left_dec;
    logic               data_last;
    logic               is_len_phase;
    logic               is_data_phase;

    assign accept         = payload.valid && payload.ready;
    assign payload.ready  = !out_valid_reg || labels.ready;
    assign cfg.ready      = 1'b1;

    assign frame_bad = ({6'd0, payload.frame_length} < MIN_FRAME_LEN)
                    || ({6'd0, payload.frame_length} > MAX_FRAME_BYTES);
    assign len_zero  = (payload.data_byte == '0);
    assign end_pos   = {1'b0, pos_reg} + {{FLEN_W{1'b0}}, 1'b1}
                     + {{(FLEN_W-DATA_W+1){1'b0}}, payload.data_byte};
    // user data may end exactly at the frame end, EPC and TID must leave room
    assign fits      = (phase_reg == PH_USER_LEN) ? (end_pos <= {1'b0, flen_reg})
                                                  : (end_pos <  {1'b0, flen_reg});
    assign len_bad   = !fits || ({1'b0, payload.data_byte} >= limit_reg);
    assign left_dec  = left_reg - {{(DATA_W-1){1'b0}}, 1'b1};
    assign data_last = (left_dec == '0);

    assign is_len_phase  = (phase_reg == PH_EPC_LEN) || (phase_reg == PH_TID_LEN)
                        || (phase_reg == PH_USER_LEN);
    assign is_data_phase = (phase_reg == PH_EPC) || (phase_reg == PH_TID)
                        || (phase_reg == PH_USER);

    // Next-state logic
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        left_next     = left_reg;
        flen_next     = flen_reg;
        finished_next = finished_reg;
        idx_next      = idx_reg;
        if (payload.frame_start)
        begin
            finished_next = frame_bad;
            flen_next     = payload.frame_length;
            pos_next      = {{(FLEN_W-1){1'b0}}, 1'b1};
            left_next     = '0;
            idx_next      = '0;
            phase_next    = frame_bad ? PH_IDLE : PH_EPC_LEN;
        end
        else if (!finished_reg)
        begin
            pos_next = pos_reg + {{(FLEN_W-1){1'b0}}, 1'b1};
            case (phase_reg)
                PH_EPC_LEN, PH_TID_LEN, PH_USER_LEN:
                begin
                    if (len_zero)
                    begin
                        case (phase_reg)
                            PH_EPC_LEN: phase_next = PH_TID_LEN;
                            PH_TID_LEN: phase_next = PH_USER_LEN;
                            default:
                            begin
                                phase_next    = PH_IDLE;
                                finished_next = 1'b1;
                                left_next     = '0;
                                idx_next      = '0;
                            end
                        endcase
                    end
                    else if (len_bad)
                    begin
                        phase_next    = PH_IDLE;
                        finished_next = 1'b1;
                        left_next     = '0;
                        idx_next      = '0;
                    end
                    else
                    begin
                        left_next = payload.data_byte;
                        idx_next  = '0;
                        case (phase_reg)
                            PH_EPC_LEN: phase_next = PH_EPC;
                            PH_TID_LEN: phase_next = PH_TID;
                            default:    phase_next = PH_USER;
                        endcase
                    end
                end
                PH_EPC, PH_TID, PH_USER:
                begin
                    idx_next  = idx_reg + {{(DATA_W-1){1'b0}}, 1'b1};
                    left_next = left_dec;
                    if (data_last)
                    begin
                        case (phase_reg)
                            PH_EPC: phase_next = PH_TID_LEN;
                            PH_TID: phase_next = PH_USER_LEN;
                            default:
                            begin
                                phase_next    = PH_IDLE;
                                finished_next = 1'b1;
                                left_next     = '0;
                                idx_next      = '0;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // open frame with no live phase: close it
                    phase_next    = PH_IDLE;
                    finished_next = 1'b1;
                    left_next     = '0;
                    idx_next      = '0;
                end
            endcase
        end
    end

    // Result logic
    always_comb
    begin
        kind_next = KIND_IGNORED;
        off_next  = '0;
        err_next  = 1'b0;
        done_next = 1'b0;
        if (payload.frame_start)
        begin
            kind_next = KIND_ANTENNA;
            err_next  = frame_bad;
        end
        else if (!finished_reg)
        begin
            if (is_len_phase)
            begin
                kind_next = phase_reg;
                if (len_zero)
                    done_next = (phase_reg == PH_USER_LEN);
                else
                    err_next  = len_bad;
            end
            else if (is_data_phase)
            begin
                kind_next = phase_reg;
                off_next  = idx_reg;
                done_next = data_last && (phase_reg == PH_USER);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            left_reg      <= '0;
            flen_reg      <= '0;
            finished_reg  <= 1'b1;
            idx_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_reg <= cfg.field_len_limit;
            if (accept)
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                left_reg     <= left_next;
                flen_reg     <= flen_next;
                finished_reg <= finished_next;
                idx_reg      <= idx_next;
            end
            if (payload.ready)
                out_valid_reg <= payload.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_next;
            value_reg <= payload.data_byte;
            off_reg   <= off_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
        end
    end

    assign labels.valid        = out_valid_reg;
    assign labels.field_kind   = kind_reg;
    assign labels.byte_value   = value_reg;
    assign labels.field_offset = off_reg;
    assign labels.parse_error  = err_reg;
    assign labels.parse_done   = done_reg;

endmodule

[rtl/core/rfp_checker.sv]
// Port-level checker for the RFID tag-read field parser, bound to the top level.
// Depends on rfp_pkg and rfid_tag_read_field_parser_top_macros.svh.
`include "rfid_tag_read_field_parser_top_macros.svh"

module rfp_checker import rfp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [KIND_W-1:0] field_kind,
    input logic [DATA_W-1:0] byte_value,
    input logic [DATA_W-1:0] field_offset,
    input logic              parse_error,
    input logic              parse_done
);

    // a held result keeps its contents
    `RFP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(field_kind) && $stable(byte_value) && $stable(field_offset) && $stable(parse_error) && $stable(parse_done), "result changed while stalled")

    // every taken byte has its result on the next cycle
    `RFP_ASSERT(a_one_cycle, clk, rst_n, in_valid && in_ready |=> out_valid, "no result after accepted byte")

    `RFP_ASSERT(a_err_done, clk, rst_n, out_valid |-> !(parse_error && parse_done), "error and done together")

    `RFP_ASSERT(a_ignored, clk, rst_n, out_valid && (field_kind == KIND_IGNORED) |-> (field_offset == '0) && !parse_error && !parse_done, "ignored byte carries flags or offset")

    `RFP_ASSERT(a_done_kind, clk, rst_n, out_valid && parse_done |-> (field_kind == KIND_USER_LEN) || (field_kind == KIND_USER), "done outside user field")

endmodule

bind rfid_tag_read_field_parser_top rfp_checker u_rfp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (payload.valid),
    .in_ready     (payload.ready),
    .out_valid    (labels.valid),
    .out_ready    (labels.ready),
    .field_kind   (labels.field_kind),
    .byte_value   (labels.byte_value),
    .field_offset (labels.field_offset),
    .parse_error  (labels.parse_error),
    .parse_done   (labels.parse_done)
);

[tb/rfp_tb_pkg.sv]
// Scoreboard for the RFID tag-read field parser testbench: byte classifier and result queue.
// Depends on rfp_pkg for widths, phase enum and field kind codes.
package rfp_tb_pkg;
    import rfp_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] offset;
        logic              err;
        logic              done;
    } field_label_t;

    class label_scoreboard;
        phase_t             phase;
        logic [FLEN_W-1:0]  next_pos;
        logic [DATA_W-1:0]  bytes_left;
        logic [FLEN_W-1:0]  frame_len;
        logic               finished;
        logic [DATA_W-1:0]  data_idx;
        logic [LIMIT_W-1:0] len_limit;
        field_label_t       expected_labels[$];
        int                 mismatches;
        int                 results_seen;
        int                 bytes_seen;
        int                 frames_started;
        int                 frames_done;
        int                 frames_failed;
        int                 bytes_ignored;

        function new();
            phase          = PH_IDLE;
            next_pos       = '0;
            bytes_left     = '0;
            frame_len      = '0;
            finished       = 1'b1;
            data_idx       = '0;
            len_limit      = LIMIT_RESET;
            mismatches     = 0;
            results_seen   = 0;
            bytes_seen     = 0;
            frames_started = 0;
            frames_done    = 0;
            frames_failed  = 0;
            bytes_ignored  = 0;
        endfunction

        function void close_frame();
            finished   = 1'b1;
            phase      = PH_IDLE;
            bytes_left = '0;
            data_idx   = '0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] v);
            len_limit = v;
        endfunction

        function int pending();
            return expected_labels.size();
        endfunction

        // Classify one accepted byte and queue the label it should produce
        function void note_byte(logic [DATA_W-1:0] d, logic s, logic [FLEN_W-1:0] fl);
            field_label_t      lab;
            logic [FLEN_W-1:0] here;
            int                reach;
            bit                fits;
            lab.kind   = KIND_IGNORED;
            lab.value  = d;
            lab.offset = '0;
            lab.err    = 1'b0;
            lab.done   = 1'b0;
            if (s) begin
                finished   = 1'b0;
                frame_len  = fl;
                next_pos   = 11'd1;
                bytes_left = '0;
                data_idx   = '0;
                lab.kind   = KIND_ANTENNA;
                if (fl < MIN_FRAME_LEN || fl > MAX_FRAME_LEN) begin
                    lab.err = 1'b1;
                    close_frame();
                end
                else
                    phase = PH_EPC_LEN;
            end
            else if (!finished) begin
                here     = next_pos;
                next_pos = here + 1'b1;
                case (phase)
                    PH_EPC_LEN, PH_TID_LEN, PH_USER_LEN:
                    begin
                        lab.kind = phase;
                        if (d == '0) begin
                            if (phase == PH_USER_LEN) begin
                                lab.done = 1'b1;
                                close_frame();
                            end
                            else
                                phase = phase_t'(phase + 3'd2);
                        end
                        else begin
                            // user data may end exactly on the frame, EPC and TID may not
                            reach = int'(here) + 1 + int'(d);
                            fits  = (phase == PH_USER_LEN) ? (reach <= int'(frame_len))
                                                           : (reach <  int'(frame_len));
                            if (!fits || d >= len_limit) begin
                                lab.err = 1'b1;
                                close_frame();
                            end
                            else begin
                                bytes_left = d;
                                data_idx   = '0;
                                phase      = phase_t'(phase + 3'd1);
                            end
                        end
                    end
                    PH_EPC, PH_TID, PH_USER:
                    begin
                        lab.kind   = phase;
                        lab.offset = data_idx;
                        data_idx   = data_idx + 1'b1;
                        bytes_left = bytes_left - 1'b1;
                        if (bytes_left == '0) begin
                            if (phase == PH_USER) begin
                                lab.done = 1'b1;
                                close_frame();
                            end
                            else
                                phase = phase_t'(phase + 3'd1);
                        end
                    end
                    default:
                        close_frame();
                endcase
            end
            bytes_seen++;
            if (s)
                frames_started++;
            if (lab.err)
                frames_failed++;
            if (lab.done)
                frames_done++;
            if (lab.kind == KIND_IGNORED)
                bytes_ignored++;
            expected_labels.push_back(lab);
        endfunction

        // Compare one accepted label with the oldest one queued
        function void check_label(field_label_t got);
            field_label_t want;
            results_seen++;
            if (expected_labels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("label %0d with none queued: kind %0d value %02h offset %0d err %b done %b",
                             results_seen, got.kind, got.value, got.offset, got.err, got.done);
                return;
            end
            want = expected_labels.pop_front();
            if (got.kind !== want.kind || got.value !== want.value || got.offset !== want.offset
                || got.err !== want.err || got.done !== want.done) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("label %0d mismatch: expected kind %0d value %02h offset %0d err %b done %b",
                             results_seen, want.kind, want.value, want.offset, want.err, want.done);
                    $display("                    got      kind %0d value %02h offset %0d err %b done %b",
                             got.kind, got.value, got.offset, got.err, got.done);
                end
            end
        endfunction
    endclass

endpackage

[tb/testbench.sv]
// Top-level testbench of the RFID tag-read field parser: stimulus, idling, checking, verdict.
// Depends on rfp_pkg, the interfaces in rfp_ifs.sv and rfp_tb_pkg (scoreboard).
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfp_pkg::*;
    import rfp_tb_pkg::*;

    localparam int WATCHDOG_CYCLES = 2000;

    logic clk = 1'b0;
    logic rst_n;

    rfp_cfg_if   cfg_ch ();
    rfp_byte_if  byte_ch ();
    rfp_field_if label_ch ();

    rfid_tag_read_field_parser_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .payload (byte_ch),
        .labels  (label_ch)
    );

    label_scoreboard book;

    int cur_limit    = 128;   // limit the block holds, as far as the stimulus knows
    int limits_set   = 0;
    int gap_pct      = 0;     // chance per item that the sender idles first
    int stall_pct    = 0;     // chance per cycle that the receiver starts a stall
    int hold_left    = 0;
    int quiet_cycles = 0;

    always #10 clk = ~clk;

    // Receiver: ready drops in bursts, changed on the falling edge
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            label_ch.ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            hold_left <= $urandom_range(0, 14);
            label_ch.ready <= 1'b0;
        end
        else
            label_ch.ready <= 1'b1;
    end

    // Monitor on the rising edge: check labels before noting the byte taken
    // at the same edge, so a label is never matched against its own byte.
    // Also the watchdog: cycles with no handshake on any channel.
    always @(posedge clk)
    begin
        field_label_t got;
        if (rst_n)
        begin
            if (label_ch.valid && label_ch.ready)
            begin
                got = '{label_ch.field_kind, label_ch.byte_value, label_ch.field_offset,
                        label_ch.parse_error, label_ch.parse_done};
                book.check_label(got);
            end
            if (byte_ch.valid && byte_ch.ready)
                book.note_byte(byte_ch.data_byte, byte_ch.frame_start, byte_ch.frame_length);
            if (cfg_ch.valid && cfg_ch.ready)
                book.set_limit(cfg_ch.field_len_limit);

            if ((label_ch.valid && label_ch.ready) || (byte_ch.valid && byte_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: %0d cycles without a handshake, %0d labels outstanding",
                         quiet_cycles, book.pending());
                $display("** rfid_tag_read_field_parser_top: FAILED **");
                $finish;
            end
        end
    end

    // Offer one byte; called and returns on a falling edge.
    // valid stays high between back-to-back items, only one assignment per step.
    task automatic push_byte(input logic [7:0] d, input logic s, input logic [10:0] fl);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= d;
        byte_ch.frame_start  <= s;
        byte_ch.frame_length <= fl;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and hold off until every queued label has come back
    task automatic wait_idle();
        byte_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (book.pending() != 0);
    endtask

    // Write the length limit; only called with the parser drained
    task automatic load_len_limit(input int v);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.field_len_limit <= 9'(v);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cur_limit = v;
        limits_set++;
        @(negedge clk);
    endtask

    // Field length: mostly short and legal, sometimes empty, the longest legal,
    // at the limit, or anything at all
    function automatic int pick_len();
        int r;
        int top;
        r   = $urandom_range(0, 99);
        top = cur_limit - 1;
        if (r < 2)
            return $urandom_range(0, 255);
        if (r < 3)
            return top;
        if (r < 5)
            return (top + 1 > 255) ? 255 : top + 1;
        if (r < 25 || top == 0)
            return 0;
        return $urandom_range(1, (top < 10) ? top : 10);
    endfunction

    // One tag-read payload. Usually well formed; sometimes the frame length is
    // short or random, or the frame is cut off by the next start.
    // forced_len >= 0 sets the user field length and keeps the frame intact.
    task automatic send_frame(input int forced_len);
        logic [7:0] body[$];
        int         f;
        int         len;
        int         n;
        int         r;
        int         fl;
        int         cut;
        int         i;
        body.push_back(8'($urandom_range(0, 255)));
        for (f = 0; f < 3; f++)
        begin
            len = (f == 2 && forced_len >= 0) ? forced_len : pick_len();
            body.push_back(8'(len));
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
        end
        n = body.size();
        r = $urandom_range(0, 99);
        if (forced_len >= 0 || r < 75)
            fl = n + $urandom_range(0, 3);
        else if (r < 88)
            fl = n - $urandom_range(1, 3);
        else
            fl = $urandom_range(0, 2047);
        // trailing bytes such as a CRC, ignored by the parser
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom_range(0, 255)));
        cut = body.size();
        if (forced_len < 0 && $urandom_range(0, 9) == 0)
            cut = $urandom_range(1, cut);
        for (i = 0; i < cut; i++)
            push_byte(body[i], i == 0, (i == 0) ? 11'(fl) : 11'($urandom_range(0, 2047)));
    endtask

    // Loose bytes with the odd stray frame start
    task automatic spray_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                      11'($urandom_range(0, 2047)));
    endtask

    task automatic run_phase(input int count);
        int goal;
        goal = book.bytes_seen + count;
        while (book.bytes_seen < goal)
        begin
            if ($urandom_range(0, 99) < 85)
                send_frame(-1);
            else
                spray_noise();
        end
    endtask

    initial
    begin
        book = new();
        rst_n                  = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.field_len_limit = '0;
        byte_ch.valid          = 1'b0;
        byte_ch.data_byte      = '0;
        byte_ch.frame_start    = 1'b0;
        byte_ch.frame_length   = '0;
        label_ch.ready         = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, limit at its reset value of 128
        push_byte(8'hFF, 1'b0, 11'h7FF);      // before any frame: ignored
        push_byte(8'h00, 1'b1, 11'd3);        // frame too short
        push_byte(8'h5A, 1'b1, 11'h7FF);      // frame length far above maximum
        push_byte(8'hC3, 1'b1, 11'd1025);     // one above maximum
        push_byte(8'h81, 1'b0, 11'd0);        // after an error: ignored
        // shortest legal frame, all three fields empty, done on the user length
        push_byte(8'hA5, 1'b1, 11'd4);
        push_byte(8'h00, 1'b0, 11'd0);
        push_byte(8'h00, 1'b0, 11'd0);
        push_byte(8'h00, 1'b0, 11'd0);
        push_byte(8'h7E, 1'b0, 11'd0);        // trailing byte after done
        // every field filled, user data ending exactly on the frame end
        push_byte(8'h3C, 1'b1, 11'd9);
        push_byte(8'h02, 1'b0, 11'd0);
        push_byte(8'h00, 1'b0, 11'd0);
        push_byte(8'hFF, 1'b0, 11'd0);
        push_byte(8'h01, 1'b0, 11'd0);
        push_byte(8'h96, 1'b0, 11'd0);
        push_byte(8'h02, 1'b0, 11'd0);
        push_byte(8'h12, 1'b0, 11'd0);
        push_byte(8'hED, 1'b0, 11'd0);
        // EPC length equal to the limit
        push_byte(8'h01, 1'b1, 11'd1024);
        push_byte(8'h80, 1'b0, 11'd0);
        // frame abandoned by a new start inside the EPC data
        push_byte(8'h44, 1'b1, 11'd1000);
        push_byte(8'h04, 1'b0, 11'd0);
        push_byte(8'hB7, 1'b0, 11'd0);
        // EPC ending exactly on the frame end: strict check fails
        push_byte(8'h10, 1'b1, 11'd5);
        push_byte(8'h03, 1'b0, 11'd0);

        // Random part: one limit per phase, idling varied between phases.
        // Each wait_idle also holds the sender until every label is back.
        wait_idle();
        load_len_limit(1);                    // only empty fields pass
        gap_pct   = 5;
        stall_pct = 3;
        run_phase(200);

        wait_idle();
        load_len_limit(256);                  // widest limit, no idling
        gap_pct   = 0;
        stall_pct = 0;
        send_frame(255);                      // longest field, offsets up to 254
        run_phase(200);

        wait_idle();
        load_len_limit($urandom_range(2, 255));
        gap_pct   = 15;
        stall_pct = 8;
        run_phase(200);

        wait_idle();
        load_len_limit(2);
        gap_pct   = 5;
        stall_pct = 10;
        run_phase(200);

        wait_idle();
        load_len_limit(255);
        gap_pct   = 10;
        stall_pct = 4;
        run_phase(200);

        // last stretch back at the reset limit, both sides flat out
        wait_idle();
        load_len_limit(128);
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(250);

        wait_idle();
        repeat (4) @(posedge clk);

        if (book.pending() != 0)
            $display("%0d labels never arrived", book.pending());
        $display("Covered %0d bytes: %0d frame starts, %0d parsed through, %0d rejected,",
                 book.bytes_seen, book.frames_started, book.frames_done, book.frames_failed);
        $display("%0d ignored; %0d limit writes, %0d labels checked, %0d mismatches.",
                 book.bytes_ignored, limits_set, book.results_seen, book.mismatches);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("** rfid_tag_read_field_parser_top: PASSED **");
        else
            $display("** rfid_tag_read_field_parser_top: FAILED **");
        $finish;
    end

endmodule
